### rtl/bottom_k_minhash_sketch_defines.svh
// ----------------------------------------------------------------------------
// Bottom-k sketch assertion macros
// Shared concurrent assertion shorthands, clocked on clk, reset on rst.
// ----------------------------------------------------------------------------
`ifndef BOTTOM_K_MINHASH_SKETCH_DEFINES_SVH
`define BOTTOM_K_MINHASH_SKETCH_DEFINES_SVH

// same-cycle implication
`define BKMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BKMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bkms_pkg.sv
// ----------------------------------------------------------------------------
// bkms_pkg
// Widths, codes and shared types of the bottom-k sketch store.
// ----------------------------------------------------------------------------
package bkms_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int VAL_W        = 63;
  localparam int HASH_W       = 64;
  localparam int CNT_W        = 7;
  localparam int STAT_W       = 2;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 64;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_DUMP = 1'b1;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_DUMP = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP      = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EVICTED  = 2'd3;

  localparam logic REG_MODULUS = 1'b0;
  localparam logic REG_SIZE    = 1'b1;

  localparam logic [VAL_W-1:0] MODULUS_RST = {VAL_W{1'b1}};
  localparam logic [CNT_W-1:0] SIZE_RST    = 7'd64;

  typedef struct packed {
    logic             compare;
    logic             insert;
    logic             rotate;
    logic [VAL_W-1:0] res;
    logic [CNT_W-1:0] count;
  } cell_cmd_t;

endpackage

### rtl/bkms_in_if.sv
// ----------------------------------------------------------------------------
// bkms_in_if
// Input item channel: operation and signed hash.
// ----------------------------------------------------------------------------
interface bkms_in_if import bkms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [HASH_W-1:0] hash_value;

  modport source (output valid, operation, hash_value, input ready);
  modport sink   (input valid, operation, hash_value, output ready);
endinterface

### rtl/bkms_out_if.sv
// ----------------------------------------------------------------------------
// bkms_out_if
// Result item channel of the sketch store.
// ----------------------------------------------------------------------------
interface bkms_out_if import bkms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  entry_value;
  logic              entry_valid;
  logic [CNT_W-1:0]  held_count;
  logic              last;

  modport source (output valid, kind, status, entry_value, entry_valid, held_count, last,
                  input ready);
  modport sink   (input valid, kind, status, entry_value, entry_valid, held_count, last,
                  output ready);
endinterface

### rtl/bkms_mod.sv
// ----------------------------------------------------------------------------
// bkms_mod
// Bit-serial signed residue unit: one restoring step per cycle.
// ----------------------------------------------------------------------------
module bkms_mod import bkms_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [HASH_W-1:0] raw,
  input  logic [VAL_W-1:0]  modulus,
  output logic              done,
  output logic [VAL_W-1:0]  res
);

  localparam int STEP_W = $clog2(HASH_W);

  logic              busy;
  logic              fin;
  logic [STEP_W-1:0] step;
  logic [HASH_W-1:0] rem;
  logic [HASH_W-1:0] dvd;
  logic [HASH_W-1:0] p;
  logic              neg;
  logic [HASH_W-1:0] trial;

  assign trial = {rem[HASH_W-2:0], dvd[HASH_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(HASH_W - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // zero modulus acts as one
      p   <= (modulus == '0) ? HASH_W'(1) : {1'b0, modulus};
      neg <= raw[HASH_W-1];
      dvd <= raw[HASH_W-1] ? (~raw + 1'b1) : raw;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[HASH_W-2:0], 1'b0};
      rem <= (trial >= p) ? (trial - p) : trial;
    end else if (fin) begin
      res <= (neg && rem != '0) ? VAL_W'(p - rem) : rem[VAL_W-1:0];
    end
  end

endmodule

### rtl/bkms_cell.sv
// ----------------------------------------------------------------------------
// bkms_cell
// One slot of the sorted chain: compare, shift-insert, ring rotate.
// ----------------------------------------------------------------------------
module bkms_cell import bkms_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic [VAL_W-1:0] prev_val,
  input  logic             prev_lt,
  input  logic [VAL_W-1:0] next_val,
  output logic [VAL_W-1:0] val,
  output logic             lt,
  output logic             eq,
  output logic             ge
);

  logic occ;
  assign occ = CNT_W'(IDX) < cmd.count;

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      lt <= occ && (val < cmd.res);
      eq <= occ && (val == cmd.res);
      ge <= occ && !(val < cmd.res);
    end
    if (cmd.insert) begin
      // slot at the insert point takes the residue, slots above shift up
      if (!lt) begin
        val <= prev_lt ? cmd.res : prev_val;
      end
    end else if (cmd.rotate) begin
      val <= next_val;
    end
  end

endmodule

### rtl/bottom_k_minhash_sketch.sv
// ----------------------------------------------------------------------------
// bottom_k_minhash_sketch
// Sorted, duplicate-free store of the smallest hash residues (bottom-k).
// ----------------------------------------------------------------------------
// An add item goes through the bit-serial residue unit (one bit per cycle),
// a compare across the cell chain and an update that waits for the output
// register. A dump item rotates the cell ring once through all CAPACITY
// slots, one slot a cycle while the output is not stalled, emitting the
// occupied ones from the front, and so ends in its original order. An empty
// dump gives one item with entry_valid low. One item is in work at a time;
// the finished result sits in an output register. The store needs no
// clearing pass after reset: only slots below the count are ever read.
// Registers: modulus at byte 0, sketch_size at byte 8 (64-bit data).
// Lowering sketch_size shrinks the store by one entry per duplicate add.
// ----------------------------------------------------------------------------
`include "bottom_k_minhash_sketch_defines.svh"

module bottom_k_minhash_sketch import bkms_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  bkms_in_if.sink           item_in,
  bkms_out_if.source        item_out
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RED   = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_DUMP  = 3'd4;
  localparam logic [2:0] S_EMPTY = 3'd5;

  logic [2:0]        state;
  logic [VAL_W-1:0]  modulus;
  logic [CNT_W-1:0]  sketch_size;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  dcnt;
  logic [CNT_W-1:0]  limit;
  logic              red_done;
  logic [VAL_W-1:0]  red_res;
  logic              start;
  logic              load_ok;
  logic              o_load;
  logic              dup;
  logic              any_ge;
  logic              full;
  logic [STAT_W-1:0] stat;
  cell_cmd_t         cmd;

  logic [VAL_W-1:0]  val_w [CAPACITY];
  logic [CAPACITY-1:0] lt_w;
  logic [CAPACITY-1:0] eq_w;
  logic [CAPACITY-1:0] ge_w;

  // output register
  logic              ovld;
  logic              o_kind;
  logic [STAT_W-1:0] o_status;
  logic [VAL_W-1:0]  o_value;
  logic              o_evalid;
  logic [CNT_W-1:0]  o_held;
  logic              o_last;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= MODULUS_RST;
      sketch_size <= SIZE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3])
        REG_MODULUS: modulus     <= pwdata[VAL_W-1:0];
        REG_SIZE:    sketch_size <= pwdata[CNT_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_MODULUS: prdata = {{(DATA_W-VAL_W){1'b0}}, modulus};
      REG_SIZE:    prdata = {{(DATA_W-CNT_W){1'b0}}, sketch_size};
      default:     prdata = '0;
    endcase
  end

  // ---------------- residue unit ----------------
  assign start = item_in.valid && item_in.ready && (item_in.operation == OP_ADD);

  bkms_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .raw     (item_in.hash_value),
    .modulus (modulus),
    .done    (red_done),
    .res     (red_res)
  );

  // ---------------- cell chain ----------------
  assign load_ok = !ovld || item_out.ready;

  always_comb begin
    cmd.compare = (state == S_CMP);
    cmd.insert  = (state == S_UPD) && load_ok && !dup && (!full || any_ge);
    cmd.rotate  = (state == S_DUMP) && (dcnt >= count || load_ok);
    cmd.res     = red_res;
    cmd.count   = count;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    bkms_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .prev_val (val_w[(g + CAPACITY - 1) % CAPACITY]),
      .prev_lt  ((g == 0) ? 1'b1 : lt_w[(g + CAPACITY - 1) % CAPACITY]),
      .next_val (val_w[(g + 1) % CAPACITY]),
      .val      (val_w[g]),
      .lt       (lt_w[g]),
      .eq       (eq_w[g]),
      .ge       (ge_w[g])
    );
  end

  // ---------------- add decision ----------------
  assign limit  = (sketch_size > CNT_W'(CAPACITY)) ? CNT_W'(CAPACITY) : sketch_size;
  assign dup    = |eq_w;
  assign any_ge = |ge_w;
  assign full   = count >= limit;

  always_comb begin
    count_next = count;
    priority if (dup) begin
      stat = ST_DUP;
      if (count > limit) begin
        count_next = count - 1'b1;
      end
    end else if (full && !any_ge) begin
      stat = ST_DROPPED;
    end else if (full) begin
      stat = ST_EVICTED;
    end else begin
      stat       = ST_INSERTED;
      count_next = count + 1'b1;
    end
  end

  // ---------------- sequencer ----------------
  assign item_in.ready = (state == S_IDLE);

  // a new result enters the output register this cycle
  assign o_load = load_ok && ((state == S_UPD) || (state == S_EMPTY) ||
                              (state == S_DUMP && dcnt < count));

  always_ff @(posedge clk) begin
    if (rst) begin
      ovld <= 1'b0;
    end else if (o_load) begin
      ovld <= 1'b1;
    end else if (item_out.ready) begin
      ovld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      dcnt  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (item_in.valid) begin
            if (item_in.operation == OP_ADD) begin
              state <= S_RED;
            end else begin
              dcnt  <= '0;
              state <= (count == '0) ? S_EMPTY : S_DUMP;
            end
          end
        end
        S_RED: begin
          if (red_done) begin
            state <= S_CMP;
          end
        end
        S_CMP: state <= S_UPD;
        S_UPD: begin
          if (load_ok) begin
            count <= count_next;
            state <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (cmd.rotate) begin
            dcnt <= dcnt + 1'b1;
            if (dcnt == CNT_W'(CAPACITY - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        S_EMPTY: begin
          if (load_ok) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_UPD && load_ok) begin
      o_kind   <= KIND_ADD;
      o_status <= stat;
      o_value  <= red_res;
      o_evalid <= 1'b1;
      o_held   <= count_next;
      o_last   <= 1'b1;
    end else if (state == S_DUMP && load_ok && dcnt < count) begin
      o_kind   <= KIND_DUMP;
      o_status <= ST_INSERTED;
      o_value  <= val_w[0];
      o_evalid <= 1'b1;
      o_held   <= count;
      o_last   <= (dcnt == count - 1'b1);
    end else if (state == S_EMPTY && load_ok) begin
      o_kind   <= KIND_DUMP;
      o_status <= ST_INSERTED;
      o_value  <= '0;
      o_evalid <= 1'b0;
      o_held   <= '0;
      o_last   <= 1'b1;
    end
  end

  assign item_out.valid       = ovld;
  assign item_out.kind        = o_kind;
  assign item_out.status      = o_status;
  assign item_out.entry_value = o_value;
  assign item_out.entry_valid = o_evalid;
  assign item_out.held_count  = o_held;
  assign item_out.last        = o_last;

  // ---------------- assertions ----------------
  `BKMS_ASSERT_NOW(a_count_cap, 1'b1, count <= CNT_W'(CAPACITY), "count above capacity")
  `BKMS_ASSERT_NEXT(a_busy_after_accept, item_in.valid && item_in.ready, !item_in.ready,
                    "second item taken while busy")
  `BKMS_ASSERT_NEXT(a_dup_no_grow, state == S_UPD && load_ok && dup, count <= $past(count),
                    "duplicate grew the store")
  `BKMS_ASSERT_NOW(a_red_only_waiting, red_done, state == S_RED,
                   "residue done outside wait state")

endmodule
